>>> rtl/core/wcrs_pkg.sv
// Shared types, constants and cosine ROM for the warmup/cosine rate schedule unit.
`default_nettype none
package wcrs_pkg;

  localparam int RATE_BITS   = 24;
  localparam int STEP_BITS   = 32;
  localparam int COS_ENTRIES = 256;
  localparam int IDX_BITS    = $clog2(COS_ENTRIES + 1);
  localparam int POS_BITS    = $clog2(2 * COS_ENTRIES + 1);

  localparam int MOD_STAGES  = STEP_BITS;
  localparam int QUO_BITS    = RATE_BITS;
  localparam int DEN_BITS    = STEP_BITS + 1;
  localparam int NUM_BITS    = DEN_BITS + QUO_BITS;

  localparam longint PI_HALF_Q30 = 64'd1686629713;
  localparam longint ONE_Q30     = 64'd1073741824;
  localparam int     ROM_SH      = (RATE_BITS >= 30) ? RATE_BITS - 30 : 30 - RATE_BITS;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_BASE   = 2'd1;
  localparam logic [1:0] REG_WARMUP = 2'd2;
  localparam logic [1:0] REG_TOTAL  = 2'd3;

  // Mode codes; the unused code behaves as plain cosine
  localparam logic [1:0] MODE_COS   = 2'd0;
  localparam logic [1:0] MODE_EPOCH = 2'd1;
  localparam logic [1:0] MODE_WSD   = 2'd2;

  // Phase codes
  localparam logic [1:0] PH_WARMUP = 2'd0;
  localparam logic [1:0] PH_HOLD   = 2'd1;
  localparam logic [1:0] PH_DECAY  = 2'd2;

  typedef enum logic [2:0] {
    KIND_WARM,
    KIND_COS,
    KIND_WSD,
    KIND_FLOOR,
    KIND_BASE
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] phase;
  } div_tag_t;

  typedef logic [COS_ENTRIES:0][RATE_BITS:0] cos_rom_t;

  // Clamps one Horner step of the cosine series at zero
  function automatic longint cos_clamp(input longint v);
    longint r;
    r = v;
    if (r < 0) r = 0;
    return r;
  endfunction

  function automatic cos_rom_t cos_rom_build();
    cos_rom_t rom;
    longint   theta;
    longint   x2;
    longint   t;
    longint   v;
    for (int k = 0; k <= COS_ENTRIES; k++) begin
      theta = (longint'(k) * PI_HALF_Q30 + longint'(COS_ENTRIES / 2)) / COS_ENTRIES;
      x2 = (theta * theta) >>> 30;
      t  = ONE_Q30;
      t  = cos_clamp(ONE_Q30 - (((x2 * t) >>> 30) / 132));
      t  = cos_clamp(ONE_Q30 - (((x2 * t) >>> 30) / 90));
      t  = cos_clamp(ONE_Q30 - (((x2 * t) >>> 30) / 56));
      t  = cos_clamp(ONE_Q30 - (((x2 * t) >>> 30) / 30));
      t  = cos_clamp(ONE_Q30 - (((x2 * t) >>> 30) / 12));
      t  = cos_clamp(ONE_Q30 - (((x2 * t) >>> 30) / 2));
      if (RATE_BITS >= 30) begin
        v = t <<< ROM_SH;
      end else begin
        v = (t + ((longint'(1) <<< ROM_SH) >>> 1)) >>> ROM_SH;
      end
      rom[k] = v[RATE_BITS:0];
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = cos_rom_build();

endpackage
`default_nettype wire

>>> rtl/core/wcrs_mod.sv
// Pipelined restoring modulo unit: one remainder bit per stage.
`default_nettype none
module wcrs_mod
  import wcrs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [STEP_BITS-1:0] step_i,
  input  wire logic [STEP_BITS-1:0] divisor_i,
  output logic                      valid_o,
  output logic [STEP_BITS-1:0]      rem_o,
  output logic [STEP_BITS-1:0]      step_o
);

  logic [MOD_STAGES-1:0] v_q;
  logic [STEP_BITS-1:0]  r_q   [MOD_STAGES];
  logic [STEP_BITS-1:0]  sh_q  [MOD_STAGES];
  logic [STEP_BITS-1:0]  raw_q [MOD_STAGES];

  for (genvar j = 0; j < MOD_STAGES; j++) begin : g_stage
    logic                 v_in;
    logic [STEP_BITS-1:0] r_in;
    logic [STEP_BITS-1:0] sh_in;
    logic [STEP_BITS-1:0] raw_in;
    logic [STEP_BITS:0]   trial;
    logic [STEP_BITS:0]   diff;
    logic [STEP_BITS-1:0] r_d;

    if (j == 0) begin : g_first
      assign v_in   = valid_i;
      assign r_in   = '0;
      assign sh_in  = step_i;
      assign raw_in = step_i;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign r_in   = r_q[j-1];
      assign sh_in  = sh_q[j-1];
      assign raw_in = raw_q[j-1];
    end

    always_comb begin
      trial = {r_in, sh_in[STEP_BITS-1]};
      diff  = trial - {1'b0, divisor_i};
      r_d   = (trial >= {1'b0, divisor_i}) ? diff[STEP_BITS-1:0] : trial[STEP_BITS-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= r_d;
        sh_q[j]  <= {sh_in[STEP_BITS-2:0], 1'b0};
        raw_q[j] <= raw_in;
      end
    end
  end

  assign valid_o = v_q[MOD_STAGES-1];
  assign rem_o   = r_q[MOD_STAGES-1];
  assign step_o  = raw_q[MOD_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/core/wcrs_div.sv
// Pipelined restoring divider: one quotient bit per stage.
`default_nettype none
module wcrs_div
  import wcrs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [NUM_BITS-1:0] num_i,
  input  wire logic [DEN_BITS-1:0] den_i,
  input  wire div_tag_t            tag_i,
  output logic                     valid_o,
  output logic [QUO_BITS-1:0]      quo_o,
  output div_tag_t                 tag_o
);

  logic [QUO_BITS-1:0] v_q;
  logic [DEN_BITS-1:0] r_q   [QUO_BITS];
  logic [QUO_BITS-1:0] sh_q  [QUO_BITS];
  logic [DEN_BITS-1:0] den_q [QUO_BITS];
  div_tag_t            tag_q [QUO_BITS];

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
    logic                v_in;
    logic [DEN_BITS-1:0] r_in;
    logic [QUO_BITS-1:0] sh_in;
    logic [DEN_BITS-1:0] den_in;
    div_tag_t            tag_in;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                ge;

    if (j == 0) begin : g_first
      assign v_in   = valid_i;
      assign r_in   = num_i[NUM_BITS-1:QUO_BITS];
      assign sh_in  = num_i[QUO_BITS-1:0];
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign r_in   = r_q[j-1];
      assign sh_in  = sh_q[j-1];
      assign den_in = den_q[j-1];
      assign tag_in = tag_q[j-1];
    end

    always_comb begin
      trial = {r_in, sh_in[QUO_BITS-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        sh_q[j]  <= {sh_in[QUO_BITS-2:0], ge};
        den_q[j] <= den_in;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign valid_o = v_q[QUO_BITS-1];
  assign quo_o   = sh_q[QUO_BITS-1];
  assign tag_o   = tag_q[QUO_BITS-1];

endmodule
`default_nettype wire

>>> rtl/core/warmup_cosine_rate_schedule_unit.sv
// Top level of the warmup/cosine learning-rate schedule pipeline.
// Pipeline from request acceptance to result valid: 32 modulo stages,
// two setup stages, 24 divider stages, three cosine/blend stages.
// Throughput: one request per cycle; the whole pipeline freezes while a result is stalled.
// Reset: clears all valid bits and loads mode 0, base_rate 0, warmup 1, total 1.
`default_nettype none
module warmup_cosine_rate_schedule_unit
  import wcrs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [STEP_BITS-1:0] step_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [RATE_BITS-1:0]      learning_rate_o,
  output logic [1:0]                phase_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // ---------------------------------------------------------------------------
  logic [1:0]           mode_q;
  logic [RATE_BITS-1:0] base_q;
  logic [23:0]          warm_q;
  logic [STEP_BITS-1:0] total_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_COS;
      base_q  <= '0;
      warm_q  <= 24'd1;
      total_q <= 32'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MODE:   mode_q  <= cfg_data_i[1:0];
        REG_BASE:   base_q  <= cfg_data_i[RATE_BITS-1:0];
        REG_WARMUP: warm_q  <= cfg_data_i[23:0];
        REG_TOTAL:  total_q <= cfg_data_i;
        default:    mode_q  <= mode_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Derived configuration. Registered in two steps after a write (the quotients,
  // then the derived values), long before a request reaches the first stage that reads it.
  // total/10 uses the exact 32-bit reciprocal 0xCCCCCCCD >> 35, base/100 uses
  // 0x51EB851F >> 37.
  // ---------------------------------------------------------------------------
  logic [63:0]          tenth_prod;
  logic [55:0]          hund_prod;
  logic [28:0]          q10_q;
  logic [18:0]          fl_q;
  logic [STEP_BITS-1:0] r10;
  logic [STEP_BITS-1:0] ceil10;
  logic [23:0]          w_d;
  logic [23:0]          w_q;
  logic [STEP_BITS-1:0] knee_q;
  logic [RATE_BITS-1:0] floor_q;
  logic [RATE_BITS-1:0] diff_q;

  assign tenth_prod = 64'(total_q) * 64'(32'hCCCCCCCD);
  assign hund_prod  = 56'(base_q) * 56'(32'h51EB851F);

  always_ff @(posedge clk_i) begin
    q10_q <= tenth_prod[63:35];
    fl_q  <= hund_prod[55:37];
  end

  always_comb begin
    r10    = total_q - ({3'b0, q10_q} * 32'd10);
    ceil10 = {3'b0, q10_q} + {31'b0, (r10 != '0)};
    // A horizon shorter than the warmup shrinks warmup to a tenth of it
    if (total_q < {8'b0, warm_q}) begin
      w_d = (q10_q == '0) ? 24'd1 : q10_q[23:0];
    end else begin
      w_d = (warm_q == '0) ? 24'd1 : warm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    knee_q  <= total_q - ceil10;       // floor(total*9/10)
    floor_q <= {5'b0, fl_q};
    diff_q  <= base_q - {5'b0, fl_q};
  end

  // ---------------------------------------------------------------------------
  // Global advance: hold every stage while the result register is stalled.
  // ---------------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------------
  // Epoch wrap: step modulo total.
  // ---------------------------------------------------------------------------
  logic                 mod_valid;
  logic [STEP_BITS-1:0] mod_rem;
  logic [STEP_BITS-1:0] mod_raw;

  wcrs_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .step_i    (step_i),
    .divisor_i (total_q),
    .valid_o   (mod_valid),
    .rem_o     (mod_rem),
    .step_o    (mod_raw)
  );

  // ---------------------------------------------------------------------------
  // Setup stage: classify the step and pick the division operands.
  //   warmup : base*(s+1) / W
  //   cosine : (1024-scaled (s-W) + D) / 2D  -> table position
  //   WSD    : (diff*(total-s) + den/2) / den, den = total - knee
  // ---------------------------------------------------------------------------
  logic [STEP_BITS-1:0] s_eff;
  logic [STEP_BITS-1:0] wsd_den;
  kind_e                kind_d;
  logic [1:0]           ph_d;
  logic [RATE_BITS-1:0] a_d;
  logic [DEN_BITS-1:0]  b_d;
  logic [DEN_BITS-1:0]  add_d;
  logic [DEN_BITS-1:0]  den_d;

  logic                 p2_valid_q;
  div_tag_t             p2_tag_q;
  logic [RATE_BITS-1:0] p2_a_q;
  logic [DEN_BITS-1:0]  p2_b_q;
  logic [DEN_BITS-1:0]  p2_add_q;
  logic [DEN_BITS-1:0]  p2_den_q;

  always_comb begin
    s_eff   = ((mode_q == MODE_EPOCH) && (total_q != '0)) ? mod_rem : mod_raw;
    wsd_den = total_q - knee_q;
    kind_d  = KIND_FLOOR;
    ph_d    = PH_DECAY;
    a_d     = '0;
    b_d     = '0;
    add_d   = '0;
    den_d   = DEN_BITS'(1);
    if (s_eff < {8'b0, w_q}) begin
      kind_d = KIND_WARM;
      ph_d   = PH_WARMUP;
      a_d    = base_q;
      b_d    = {1'b0, s_eff} + DEN_BITS'(1);
      den_d  = {9'b0, w_q};
    end else if (mode_q == MODE_WSD) begin
      if (s_eff > knee_q) begin
        if ((wsd_den != '0) && (s_eff < total_q)) begin
          kind_d = KIND_WSD;
          a_d    = diff_q;
          b_d    = {1'b0, total_q - s_eff};
          add_d  = {2'b0, wsd_den[STEP_BITS-1:1]};
          den_d  = {1'b0, wsd_den};
        end
      end else begin
        kind_d = KIND_BASE;
        ph_d   = PH_HOLD;
      end
    end else begin
      if ((total_q > {8'b0, w_q}) && (s_eff < total_q)) begin
        kind_d = KIND_COS;
        a_d    = RATE_BITS'(4 * COS_ENTRIES);
        b_d    = {1'b0, s_eff - {8'b0, w_q}};
        add_d  = {1'b0, total_q - {8'b0, w_q}};
        den_d  = {total_q - {8'b0, w_q}, 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (en) begin
      p2_valid_q <= mod_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_tag_q <= '{kind: kind_d, phase: ph_d};
      p2_a_q   <= a_d;
      p2_b_q   <= b_d;
      p2_add_q <= add_d;
      p2_den_q <= den_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Numerator stage: one multiply plus addend.
  // ---------------------------------------------------------------------------
  logic                p3_valid_q;
  div_tag_t            p3_tag_q;
  logic [NUM_BITS-1:0] p3_num_q;
  logic [DEN_BITS-1:0] p3_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else if (en) begin
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_tag_q <= p2_tag_q;
      p3_num_q <= (NUM_BITS'(p2_a_q) * NUM_BITS'(p2_b_q)) + NUM_BITS'(p2_add_q);
      p3_den_q <= p2_den_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider. Every active case has a quotient below 2^24.
  // ---------------------------------------------------------------------------
  logic                div_valid;
  logic [QUO_BITS-1:0] div_quo;
  div_tag_t            div_tag;

  wcrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p3_valid_q),
    .num_i   (p3_num_q),
    .den_i   (p3_den_q),
    .tag_i   (p3_tag_q),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .tag_o   (div_tag)
  );

  // ---------------------------------------------------------------------------
  // Cosine stage: fold the half-wave position onto the quarter-wave ROM.
  // ---------------------------------------------------------------------------
  logic [POS_BITS-1:0]  pos;
  logic [IDX_BITS-1:0]  idx;
  logic [RATE_BITS:0]   cval;
  logic [RATE_BITS+1:0] csum;

  logic                 p4_valid_q;
  div_tag_t             p4_tag_q;
  logic [QUO_BITS-1:0]  p4_quo_q;
  logic [RATE_BITS:0]   p4_coeff_q;

  always_comb begin
    pos = (div_quo > QUO_BITS'(2 * COS_ENTRIES)) ? POS_BITS'(2 * COS_ENTRIES)
                                                  : div_quo[POS_BITS-1:0];
    if (pos <= POS_BITS'(COS_ENTRIES)) begin
      idx = pos[IDX_BITS-1:0];
    end else begin
      idx = IDX_BITS'(POS_BITS'(2 * COS_ENTRIES) - pos);
    end
    cval = COS_ROM[idx];
    // Second quarter mirrors with a negative sign
    if (pos <= POS_BITS'(COS_ENTRIES)) begin
      csum = (RATE_BITS+2)'(1 << RATE_BITS) + {1'b0, cval};
    end else begin
      csum = (RATE_BITS+2)'(1 << RATE_BITS) - {1'b0, cval};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_valid_q <= 1'b0;
    end else if (en) begin
      p4_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_tag_q   <= div_tag;
      p4_quo_q   <= div_quo;
      p4_coeff_q <= csum[RATE_BITS+1:1];
    end
  end

  // ---------------------------------------------------------------------------
  // Blend multiply: (base - floor) * coefficient.
  // ---------------------------------------------------------------------------
  logic                     p5_valid_q;
  div_tag_t                 p5_tag_q;
  logic [QUO_BITS-1:0]      p5_quo_q;
  logic [2*RATE_BITS:0]     p5_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_valid_q <= 1'b0;
    end else if (en) begin
      p5_valid_q <= p4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_tag_q  <= p4_tag_q;
      p5_quo_q  <= p4_quo_q;
      p5_prod_q <= (2*RATE_BITS+1)'(diff_q) * (2*RATE_BITS+1)'(p4_coeff_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: round the blend and pick the rate for each case.
  // ---------------------------------------------------------------------------
  logic [2*RATE_BITS:0] blend_rnd;
  logic [RATE_BITS:0]   lr_d;
  logic [RATE_BITS-1:0] lr_q;
  logic [1:0]           ph_q;

  always_comb begin
    blend_rnd = p5_prod_q + (2*RATE_BITS+1)'(1 << (RATE_BITS - 1));
    case (p5_tag_q.kind)
      KIND_WARM:  lr_d = {1'b0, p5_quo_q};
      KIND_COS:   lr_d = {1'b0, floor_q} + blend_rnd[2*RATE_BITS:RATE_BITS];
      KIND_WSD:   lr_d = {1'b0, floor_q} + {1'b0, p5_quo_q};
      KIND_BASE:  lr_d = {1'b0, base_q};
      default:    lr_d = {1'b0, floor_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= p5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lr_q <= lr_d[RATE_BITS-1:0];
      ph_q <= p5_tag_q.phase;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign learning_rate_o = lr_q;
  assign phase_o         = ph_q;

endmodule
`default_nettype wire
